FILE: rtl/core/sse_pkg.sv
package sse_pkg;

    // table size default and sine pipeline depth
    localparam int COMPONENTS_DEF = 16;
    localparam int SINE_LAT       = 5;
    localparam int CFG_W          = 5;
    localparam int TERM_W         = 26;

    // quarter-wave polynomial coefficients, Q30
    localparam logic [31:0] COEF_A = 32'd1686629713;
    localparam logic [31:0] COEF_B = 32'd688904866;
    localparam logic [31:0] COEF_C = 32'd76016977;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_EVAL  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // classified command word held in the queue
    typedef struct packed {
        t_kind              kind;
        logic               wr_ok;
        logic [3:0]         index;
        logic               enable;
        logic signed [15:0] amplitude;
        logic signed [15:0] frequency;
        logic [15:0]        phase;
        logic [15:0]        angle;
    } t_cmd;

    // queue head toward the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

endpackage

FILE: rtl/core/sse_if.sv
interface sse_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [3:0]         index;
    logic               enable;
    logic signed [15:0] amplitude;
    logic signed [15:0] frequency;
    logic [15:0]        phase;
    logic [15:0]        angle;

    modport source (output valid, action, index, enable, amplitude, frequency, phase, angle,
                    input ready);
    modport sink   (input valid, action, index, enable, amplitude, frequency, phase, angle,
                    output ready);
endinterface

interface sse_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sin_sum;
    logic signed [31:0] cos_sum;

    modport source (output valid, sin_sum, cos_sum, input ready);
    modport sink   (input valid, sin_sum, cos_sum, output ready);
endinterface

FILE: rtl/core/sse_front.sv
module sse_front
    import sse_pkg::*;
#(
    parameter int COMPONENTS = COMPONENTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sse_in_if.sink    i_in,
    output t_qhead    o_head,
    input  logic      i_pop
);

    logic [1:0] r_cnt;
    logic       r_wp;
    logic       r_rp;
    t_cmd       r_q [2];
    t_cmd       w_cmd;
    logic       w_push;

    // classify incoming word
    always_comb begin
        w_cmd.kind      = i_in.action ? KIND_EVAL : KIND_WRITE;
        w_cmd.wr_ok     = (32'(i_in.index) < 32'(COMPONENTS));
        w_cmd.index     = i_in.index;
        w_cmd.enable    = i_in.enable;
        w_cmd.amplitude = i_in.amplitude;
        w_cmd.frequency = i_in.frequency;
        w_cmd.phase     = i_in.phase;
        w_cmd.angle     = i_in.angle;
    end

    assign i_in.ready = (r_cnt != 2'd2);
    assign w_push     = i_in.valid && i_in.ready;

    // two-entry queue
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_q[r_rp];

endmodule

FILE: rtl/core/sse_sine.sv
module sse_sine
    import sse_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [15:0]        i_arg,
    output logic               o_valid,
    output logic signed [17:0] o_sin
);

    logic [14:0] w_f;
    logic [30:0] w_x30;
    logic [61:0] w_sq;
    logic [62:0] w_p1;
    logic [31:0] w_t2in;
    logic [62:0] w_p2;
    logic [31:0] w_t3in;
    logic [62:0] w_p3;
    logic [32:0] w_rnd;
    logic [16:0] w_mag;

    logic        r1_v, r2_v, r3_v, r4_v, r5_v;
    logic        r1_neg, r2_neg, r3_neg, r4_neg;
    logic [30:0] r1_x2, r2_x2;
    logic [30:0] r1_x30, r2_x30, r3_x30;
    logic [31:0] r2_t1, r3_t2, r4_t3;
    logic signed [17:0] r5_sin;

    // quadrant fold, x and x squared
    always_comb begin
        w_f   = {1'b0, i_arg[13:0]};
        if (i_arg[14]) w_f = 15'h4000 - w_f;
        w_x30 = {w_f, 16'b0};
        w_sq  = w_x30 * w_x30;
    end

    // polynomial steps, one product per stage
    assign w_p1  = r1_x2 * COEF_C;
    assign w_t2in = COEF_B - r2_t1;
    assign w_p2  = r2_x2 * w_t2in;
    assign w_t3in = COEF_A - r3_t2;
    assign w_p3  = r3_x30 * w_t3in;
    assign w_rnd = {1'b0, r4_t3} + 33'd8192;
    assign w_mag = w_rnd[30:14];

    always_ff @(posedge i_clk) begin
        r1_x2  <= w_sq[60:30];
        r1_x30 <= w_x30;
        r1_neg <= i_arg[15];
        r2_t1  <= w_p1[61:30];
        r2_x2  <= r1_x2;
        r2_x30 <= r1_x30;
        r2_neg <= r1_neg;
        r3_t2  <= w_p2[61:30];
        r3_x30 <= r2_x30;
        r3_neg <= r2_neg;
        r4_t3  <= w_p3[61:30];
        r4_neg <= r3_neg;
        r5_sin <= r4_neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    assign o_valid = r5_v;
    assign o_sin   = r5_sin;

endmodule

FILE: rtl/core/sse_back.sv
module sse_back
    import sse_pkg::*;
#(
    parameter int COMPONENTS = COMPONENTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_qhead           i_head,
    output logic             o_pop,
    input  logic [CFG_W-1:0] i_count,
    sse_out_if.source        o_out
);

    localparam int IDX_W  = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
    localparam int CNT_W  = $clog2(COMPONENTS + 1);
    localparam int ACC_R  = TERM_W + CNT_W;
    localparam int ACC_W  = (ACC_R > 33) ? ACC_R : 33;
    localparam int ENT_W  = 49;

    t_state r_state, n_state;

    // component store and written flags
    logic [ENT_W-1:0]      r_mem [COMPONENTS];
    logic [COMPONENTS-1:0] r_vb;
    logic [ENT_W-1:0]      r_q;
    logic                  w_we;
    logic [IDX_W-1:0]      w_waddr;
    logic [31:0]           w_wide_idx;

    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_pend;
    logic [15:0]      r_angle;
    logic             w_issue;
    logic             w_load;
    logic             w_clr;

    logic               r_s1_v, r_s1_vb;
    logic               r_s2_v, r_s2_en;
    logic signed [32:0] r_s2_prod;
    logic signed [15:0] r_s2_amp;
    logic [15:0]        r_s2_phase;
    logic signed [32:0] w_prod;
    logic [15:0]        w_arg;
    logic [15:0]        w_carg;

    logic               w_sv, w_cv;
    logic signed [17:0] w_sin, w_cos;
    logic signed [15:0] r_dl_amp [SINE_LAT];
    logic               r_dl_en  [SINE_LAT];

    logic signed [33:0] w_ps, w_pc;
    logic               r_t_v;
    logic signed [TERM_W-1:0] r_ts, r_tc;
    logic signed [ACC_W-1:0]  r_acc_s, r_acc_c;

    logic               r_out_v;
    logic signed [31:0] r_out_s, r_out_c;
    logic signed [ACC_W-1:0] w_max, w_min;

    assign w_wide_idx = 32'(i_head.cmd.index);
    assign w_waddr    = w_wide_idx[IDX_W-1:0];

    // sequencer
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_n     = r_n;
        o_pop   = 1'b0;
        w_we    = 1'b0;
        w_issue = 1'b0;
        w_load  = 1'b0;
        w_clr   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    if (i_head.cmd.kind == KIND_WRITE) begin
                        w_we = i_head.cmd.wr_ok;
                    end else begin
                        w_clr = 1'b1;
                        n_i   = '0;
                        n_n   = (32'(i_count) > 32'(COMPONENTS)) ?
                                CNT_W'(COMPONENTS) : CNT_W'(i_count);
                        n_state = (n_n == '0) ? ST_DONE : ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                w_issue = 1'b1;
                n_i     = CNT_W'(r_i + 1'b1);
                if (n_i == r_n) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (r_pend == '0) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_v || o_out.ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_n     <= '0;
            r_vb    <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_n     <= n_n;
            if (w_we) r_vb[w_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_clr) r_angle <= i_head.cmd.angle;
    end

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= {i_head.cmd.enable, i_head.cmd.amplitude,
                               i_head.cmd.frequency, i_head.cmd.phase};
        end
        r_q     <= r_mem[r_i[IDX_W-1:0]];
        r_s1_vb <= r_vb[r_i[IDX_W-1:0]];
    end

    // argument stage
    assign w_prod = $signed(r_q[31:16]) * $signed({1'b0, r_angle});

    always_ff @(posedge i_clk) begin
        r_s2_prod  <= w_prod;
        r_s2_amp   <= $signed(r_q[47:32]);
        r_s2_phase <= r_q[15:0];
        r_s2_en    <= r_s1_vb & r_q[48];
    end

    assign w_arg  = r_s2_prod[23:8] + r_s2_phase;
    assign w_carg = w_arg + 16'h4000;

    sse_sine u_sin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_v),
        .i_arg   (w_arg),
        .o_valid (w_sv),
        .o_sin   (w_sin)
    );

    sse_sine u_cos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_v),
        .i_arg   (w_carg),
        .o_valid (w_cv),
        .o_sin   (w_cos)
    );

    // amplitude travels alongside the sine pipeline
    always_ff @(posedge i_clk) begin
        r_dl_amp[0] <= r_s2_amp;
        r_dl_en[0]  <= r_s2_en;
        for (int k = 1; k < SINE_LAT; k++) begin
            r_dl_amp[k] <= r_dl_amp[k-1];
            r_dl_en[k]  <= r_dl_en[k-1];
        end
    end

    // term products, rounded to Q16.16
    assign w_ps = r_dl_amp[SINE_LAT-1] * w_sin + 34'sd128;
    assign w_pc = r_dl_amp[SINE_LAT-1] * w_cos + 34'sd128;

    always_ff @(posedge i_clk) begin
        r_ts <= r_dl_en[SINE_LAT-1] ? w_ps[33:8] : '0;
        r_tc <= r_dl_en[SINE_LAT-1] ? w_pc[33:8] : '0;
    end

    // accumulators
    always_ff @(posedge i_clk) begin
        if (w_clr) begin
            r_acc_s <= '0;
            r_acc_c <= '0;
        end else if (r_t_v) begin
            r_acc_s <= r_acc_s + ACC_W'(r_ts);
            r_acc_c <= r_acc_c + ACC_W'(r_tc);
        end
    end

    // pipeline tags and in-flight count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_t_v  <= 1'b0;
            r_pend <= '0;
        end else begin
            r_s1_v <= w_issue;
            r_s2_v <= r_s1_v;
            r_t_v  <= w_sv & w_cv;
            r_pend <= r_pend + CNT_W'(w_issue) - CNT_W'(r_t_v);
        end
    end

    // saturation and output register
    assign w_max = ACC_W'(33'sh0_7FFF_FFFF);
    assign w_min = ACC_W'(-33'sh0_8000_0000);

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_s <= (r_acc_s > w_max) ? 32'h7FFF_FFFF :
                       (r_acc_s < w_min) ? 32'h8000_0000 : r_acc_s[31:0];
            r_out_c <= (r_acc_c > w_max) ? 32'h7FFF_FFFF :
                       (r_acc_c < w_min) ? 32'h8000_0000 : r_acc_c[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_load) begin
            r_out_v <= 1'b1;
        end else if (o_out.ready) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_out.valid   = r_out_v;
    assign o_out.sin_sum = r_out_s;
    assign o_out.cos_sum = r_out_c;

`ifndef SYNTHESIS
    a_acc_has_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_t_v |-> (r_pend != '0))
        else $error("term accumulated with no component in flight");

    a_done_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (r_pend == '0))
        else $error("result formed before pipeline drained");

    a_issue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ISSUE) |-> (r_i < r_n))
        else $error("component issued beyond active count");

    a_pair_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sv == w_cv)
        else $error("sine and cosine pipelines out of step");
`endif

endmodule

FILE: rtl/core/sinusoid_sum_evaluator.sv
// Channel  | Dir | Word
// i_in     | in  | action, index, enable, amplitude, frequency, phase, angle
// o_out    | out | sin_sum, cos_sum
// i_cfg_*  | in  | component_count write, no read-back
//
// The back end stores a write word with an in-range index as it pops it. For
// an evaluate word, n being the active count, one component enters the paired
// sine and cosine pipelines per cycle, then the pipelines drain.
// Synchronous active-low reset clears the entry flags, count and queue.
// A two-word queue lets input be taken while the back end works; the result
// register holds a finished word while the next one is being computed.
module sinusoid_sum_evaluator
    import sse_pkg::*;
#(
    parameter int COMPONENTS = COMPONENTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sse_in_if.sink           i_in,
    sse_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [CFG_W-1:0] r_count;
    t_qhead           w_head;
    logic             w_pop;

    // component count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
        end
    end

    sse_front #(.COMPONENTS(COMPONENTS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    sse_back #(.COMPONENTS(COMPONENTS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .i_count (r_count),
        .o_out   (o_out)
    );

endmodule
